[sv/ctlex_pkg.sv]
// ----------------------------------------------------------------------------
// ctlex_pkg: shared types and constants for the C token lexer
// Token kinds, byte classes, the result word layout and the queue geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlex_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int START_W     = 20;
    localparam int LEN_W       = 21;
    localparam int KIND_W      = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNKNOWN  = 4'd0,
        KIND_LPAREN   = 4'd1,
        KIND_RPAREN   = 4'd2,
        KIND_LBRACKET = 4'd3,
        KIND_RBRACKET = 4'd4,
        KIND_LBRACE   = 4'd5,
        KIND_RBRACE   = 4'd6,
        KIND_DOT      = 4'd7,
        KIND_COMMA    = 4'd8,
        KIND_COLON    = 4'd9,
        KIND_SEMI     = 4'd10,
        KIND_STAR     = 4'd11,
        KIND_IDENT    = 4'd12,
        KIND_EOF      = 4'd13
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        kind_t              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               ovf;
        logic               last;
    } token_t;

    // Tokens caused by one source byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } tok_pair_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] b);
        return is_alpha(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDER);
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5b:   k = KIND_LBRACKET;
            8'h5d:   k = KIND_RBRACKET;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h2e:   k = KIND_DOT;
            8'h2c:   k = KIND_COMMA;
            8'h3a:   k = KIND_COLON;
            8'h3b:   k = KIND_SEMI;
            CH_STAR: k = KIND_STAR;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/ctlex_core.sv]
// ----------------------------------------------------------------------------
// ctlex_core: lexer state and token decode
// Classifies one source byte against the lexer mode and produces up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlex_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                take,
    input  wire logic [7:0]          byte_in,
    output ctlex_pkg::tok_pair_t     pair
);
    import ctlex_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_IDENT = 6'b000010,
        MODE_SLASH = 6'b000100,
        MODE_LINE  = 6'b001000,
        MODE_BLOCK = 6'b010000,
        MODE_BSTAR = 6'b100000
    } lex_mode_t;

    lex_mode_t mode_reg, mode_next;
    offset_t   pos_reg, pos_next;
    offset_t   pend_reg, pend_next;
    logic      ovf_reg, ovf_next;

    logic      idle_emit, idle_pend, idle_eof;
    kind_t     idle_kind, pk;
    lex_mode_t idle_mode;
    logic      pre_emit, use_idle, emit_idle, eof;
    kind_t     pre_kind;
    logic [LEN_W-1:0] pre_len;
    offset_t   ident_len;
    token_t    pre_tok, idle_tok;

    // Handling of a byte from the idle mode.
    always_comb begin
        idle_emit = 1'b0;
        idle_kind = KIND_UNKNOWN;
        idle_mode = MODE_IDLE;
        idle_pend = 1'b0;
        idle_eof  = 1'b0;
        pk        = punct_kind(byte_in);
        priority if (byte_in == CH_NUL) begin
            idle_emit = 1'b1;
            idle_kind = KIND_EOF;
            idle_eof  = 1'b1;
        end else if (is_space(byte_in)) begin
            idle_emit = 1'b0;
        end else if (byte_in == CH_SLASH) begin
            idle_mode = MODE_SLASH;
            idle_pend = 1'b1;
        end else if (pk != KIND_UNKNOWN) begin
            idle_emit = 1'b1;
            idle_kind = pk;
        end else if (is_alpha(byte_in)) begin
            idle_mode = MODE_IDENT;
            idle_pend = 1'b1;
        end else begin
            idle_emit = 1'b1;
        end
    end

    assign ident_len = pos_reg - pend_reg;

    // Per-mode handling; a pending token closes first, then the byte runs as idle.
    always_comb begin
        pre_emit  = 1'b0;
        pre_kind  = KIND_UNKNOWN;
        pre_len   = LEN_W'(1);
        use_idle  = 1'b0;
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDENT: begin
                if (!is_ident_tail(byte_in)) begin
                    pre_emit = 1'b1;
                    pre_kind = KIND_IDENT;
                    pre_len  = LEN_W'(ident_len);
                    use_idle = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (byte_in == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (byte_in == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else begin
                    pre_emit = 1'b1;
                    use_idle = 1'b1;
                end
            end
            MODE_LINE: begin
                if (byte_in == CH_NUL) begin
                    use_idle = 1'b1;
                end else if ((byte_in == CH_LF) || (byte_in == CH_CR)) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BLOCK: begin
                if (byte_in == CH_NUL) begin
                    use_idle = 1'b1;
                end else if (byte_in == CH_STAR) begin
                    mode_next = MODE_BSTAR;
                end
            end
            MODE_BSTAR: begin
                if (byte_in == CH_NUL) begin
                    use_idle = 1'b1;
                end else if (byte_in == CH_SLASH) begin
                    mode_next = MODE_IDLE;
                end else if (byte_in != CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase
        if (use_idle) begin
            mode_next = idle_mode;
        end
    end

    assign emit_idle = use_idle & idle_emit;
    assign eof       = use_idle & idle_eof;

    always_comb begin
        pre_tok.kind    = pre_kind;
        pre_tok.start   = START_W'(pend_reg);
        pre_tok.length  = pre_len;
        pre_tok.ovf     = ovf_reg;
        pre_tok.last    = ~emit_idle;
        idle_tok.kind   = idle_kind;
        idle_tok.start  = START_W'(pos_reg);
        idle_tok.length = LEN_W'(1);
        idle_tok.ovf    = ovf_reg;
        idle_tok.last   = 1'b1;
        pair.count      = {1'b0, pre_emit} + {1'b0, emit_idle};
        pair.first      = pre_emit ? pre_tok : idle_tok;
        pair.second     = idle_tok;
    end

    // Next offset, pending start and overflow flag.
    always_comb begin
        pend_next = pend_reg;
        if (use_idle && idle_pend) begin
            pend_next = pos_reg;
        end
        priority if (eof) begin
            pos_next  = '0;
            pend_next = '0;
            ovf_next  = 1'b0;
        end else if (pos_reg == '1) begin
            pos_next = pos_reg;
            ovf_next = 1'b1;
        end else begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            pend_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (take) begin
            mode_reg <= eof ? MODE_IDLE : mode_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            ovf_reg  <= ovf_next;
        end
    end

`ifndef ASSERT_OFF
    a_last_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.count == 2'd2) |-> (!pair.first.last && pair.second.last))
        else $error("two tokens without a single final flag");
    a_last_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.count == 2'd1) |-> pair.first.last)
        else $error("single token not flagged final");
    a_eof_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && eof) |=> ((pos_reg == '0) && !ovf_reg && (mode_reg == MODE_IDLE)))
        else $error("end of file did not restart the offset");
`endif

endmodule

`default_nettype wire

[sv/ctlex_fifo.sv]
// ----------------------------------------------------------------------------
// ctlex_fifo: token result queue
// Takes zero to two tokens per cycle and delivers one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlex_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ctlex_pkg::tok_pair_t pair,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ctlex_pkg::token_t        head
);
    import ctlex_pkg::*;

    token_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, rd_reg;
    logic [FIFO_CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]           n_push;
    logic                 pop;

    assign n_push  = push ? pair.count : 2'd0;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid & m_ready;
    assign room    = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign head    = mem[rd_reg];
    assign cnt_next = cnt_reg + FIFO_CW'(n_push) - FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_reg] <= pair.first;
        end
        if (n_push == 2'd2) begin
            mem[wr_reg + FIFO_AW'(1)] <= pair.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + FIFO_AW'(n_push);
            rd_reg  <= rd_reg + FIFO_AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_push != 2'd0) |-> (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2)))
        else $error("push into a queue without room for two words");
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue fill beyond depth");
    a_show: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cnt_reg == '0) && (n_push != 2'd0)) |=> m_valid)
        else $error("pushed token not presented");
`endif

endmodule

`default_nettype wire

[sv/c_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// c_token_lexer_unit: streaming C source tokenizer
// One source byte per word in, one token (kind, start, length, flags) per word out.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                       | word
//  --------+-----------+-----------------------------+------------------------------
//  s_      | in        | s_valid s_ready s_byte_in   | one source byte
//  m_      | out       | m_valid m_ready m_token_*,  | one token: kind, start,
//          |           | m_offset_overflow,          | length, overflow flag and
//          |           | m_last_of_run               | final-of-byte flag
//
//  Cycles: one byte per cycle while each byte yields at most one token and the
//  sink takes a word every cycle; a byte that closes a pending token and gives
//  its own token puts both words into the queue, which m_ delivers one at a time.
//  Output: a token is queued when its byte is accepted and waits behind older words.
//  Reset: aresetn clears the lexer mode, offsets, overflow flag and the queue;
//  no clearing pass, the block is ready the first cycle after reset.
//  Stalls: s_ready depends only on queue fill (room for two words), never on m_ready.
//
`default_nettype none

module c_token_lexer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_byte_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ctlex_pkg::KIND_W-1:0]        m_token_kind,
    output logic [ctlex_pkg::START_W-1:0]       m_token_start,
    output logic [ctlex_pkg::LEN_W-1:0]         m_token_length,
    output logic                                m_offset_overflow,
    output logic                                m_last_of_run
);
    import ctlex_pkg::*;

    tok_pair_t pair;
    token_t    head;
    logic      room;
    logic      take;

    // Accept a byte only when the queue can absorb both tokens it may cause.
    assign s_ready = room;
    assign take    = s_valid & room;

    // Decode the byte against the lexer mode; advance state on accept.
    ctlex_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .byte_in (s_byte_in),
        .pair    (pair)
    );

    // Hold finished tokens until the sink takes them, one word per handshake.
    ctlex_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (take),
        .pair    (pair),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_token_kind      = head.kind;
    assign m_token_start     = head.start;
    assign m_token_length    = head.length;
    assign m_offset_overflow = head.ovf;
    assign m_last_of_run     = head.last;

endmodule

`default_nettype wire

[tb/sv/c_token_lexer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_token_lexer_unit_test: self-checking bench for the streaming C tokenizer
// Feeds source bytes through the s_ port with random gaps and checks each
// token on the m_ port against a cycle-free lexer kept in step with the
// accepted bytes. Covers punctuation, identifiers, comments, lone slashes
// and end of file.
// ----------------------------------------------------------------------------

module c_token_lexer_unit_test;

    import ctlex_pkg::*;

    localparam int          SOURCE_BYTES   = 1550;
    localparam int          DRAIN_EVERY    = 500;
    localparam int          SETTLE_CYCLES  = 16;
    localparam longint      LIMIT_CYCLES   = 5_000_000;
    localparam int unsigned MAX_OFFSET     = (1 << OFFSET_BITS) - 1;

    // One source byte waiting to go out, the idle cycles that follow its
    // acceptance, and whether to hold it until every token has come back.
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] pause;
        logic       drain;
    } src_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               ovf;
        logic               last;
    } token_rec_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BLOCK_STAR
    } scan_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid   = 1'b0;
    logic [7:0]          s_byte_in = 8'h00;
    logic                m_ready   = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [KIND_W-1:0]   m_token_kind;
    logic [START_W-1:0]  m_token_start;
    logic [LEN_W-1:0]    m_token_length;
    logic                m_offset_overflow;
    logic                m_last_of_run;

    always #2 aclk = ~aclk;

    c_token_lexer_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_in         (s_byte_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_token_kind      (m_token_kind),
        .m_token_start     (m_token_start),
        .m_token_length    (m_token_length),
        .m_offset_overflow (m_offset_overflow),
        .m_last_of_run     (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    src_word_t  source_words[$];
    token_rec_t expected_tokens[$];
    token_rec_t step_tokens[$];
    src_word_t  next_word;
    token_rec_t want;

    // Lexer shadow: mode, offset of the next byte, start of the pending
    // identifier or slash, and the saturation flag of the current file.
    scan_t   scan_mode   = SCAN_IDLE;
    offset_t next_offset = '0;
    offset_t word_start  = '0;
    logic    past_end    = 1'b0;

    logic    drain_next = 1'b0;
    int      send_calm  = 0;
    int      recv_calm  = 0;
    int      gap_left   = 0;
    int      stall_left = 0;

    int      fail_count     = 0;
    int      bytes_taken    = 0;
    int      tokens_checked = 0;
    int      files_closed   = 0;
    int      double_bytes   = 0;
    int      flagged_tokens = 0;
    longint  cycle_count    = 0;

    string      word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string      punct_chars = "()[]{}.,:;*";
    logic [7:0] blanks [6]  = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] b);
        // tab, line feed, vertical tab, form feed and carriage return are 9..13
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic letter_char(input logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        return (b < 8'h80) && (low >= "a") && (low <= "z");
    endfunction

    function automatic logic word_char(input logic [7:0] b);
        return letter_char(b) || ((b >= "0") && (b <= "9")) || (b == CH_UNDER);
    endfunction

    function automatic kind_t punct_of(input logic [7:0] b);
        case (b)
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "[":     return KIND_LBRACKET;
            "]":     return KIND_RBRACKET;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ".":     return KIND_DOT;
            ",":     return KIND_COMMA;
            ":":     return KIND_COLON;
            ";":     return KIND_SEMI;
            CH_STAR: return KIND_STAR;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Lexer shadow
    // ------------------------------------------------------------------
    task automatic add_token(input kind_t k, input offset_t s, input logic [LEN_W-1:0] n);
        step_tokens.push_back('{kind: k, start: s, length: n, ovf: past_end, last: 1'b0});
    endtask

    // Handle a byte as if nothing were pending; flag end of file.
    task automatic open_token(input logic [7:0] b, input offset_t here, output logic eof);
        eof       = 1'b0;
        scan_mode = SCAN_IDLE;
        if (b == CH_NUL) begin
            add_token(KIND_EOF, here, LEN_W'(1));
            eof = 1'b1;
        end else if (b == CH_SLASH) begin
            scan_mode  = SCAN_SLASH;
            word_start = here;
        end else if (punct_of(b) != KIND_UNKNOWN) begin
            add_token(punct_of(b), here, LEN_W'(1));
        end else if (letter_char(b)) begin
            scan_mode  = SCAN_WORD;
            word_start = here;
        end else if (!blank_char(b)) begin
            add_token(KIND_UNKNOWN, here, LEN_W'(1));
        end
    endtask

    // Advance the shadow by one accepted byte and queue the tokens it causes.
    task automatic lex_byte(input logic [7:0] b);
        offset_t          here;
        logic             eof;
        logic [LEN_W-1:0] span;
        token_rec_t       tail;
        here        = next_offset;
        eof         = 1'b0;
        step_tokens = {};
        case (scan_mode)
            SCAN_WORD: begin
                if (!word_char(b)) begin
                    span = LEN_W'(offset_t'(here - word_start));
                    add_token(KIND_IDENT, word_start, span);
                    open_token(b, here, eof);
                end
            end
            SCAN_SLASH: begin
                if (b == CH_SLASH) begin
                    scan_mode = SCAN_LINE;
                end else if (b == CH_STAR) begin
                    scan_mode = SCAN_BLOCK;
                end else begin
                    // lone slash: unknown at its own offset, then lex this byte fresh
                    add_token(KIND_UNKNOWN, word_start, LEN_W'(1));
                    open_token(b, here, eof);
                end
            end
            SCAN_LINE: begin
                if (b == CH_NUL) begin
                    open_token(b, here, eof);
                end else if ((b == CH_LF) || (b == CH_CR)) begin
                    scan_mode = SCAN_IDLE;
                end
            end
            SCAN_BLOCK: begin
                if (b == CH_NUL) begin
                    open_token(b, here, eof);
                end else if (b == CH_STAR) begin
                    scan_mode = SCAN_BLOCK_STAR;
                end
            end
            SCAN_BLOCK_STAR: begin
                if (b == CH_NUL) begin
                    open_token(b, here, eof);
                end else if (b == CH_SLASH) begin
                    scan_mode = SCAN_IDLE;
                end else if (b != CH_STAR) begin
                    scan_mode = SCAN_BLOCK;
                end
            end
            default: begin
                open_token(b, here, eof);
            end
        endcase

        // Mark the final token of this byte.
        if (step_tokens.size() != 0) begin
            tail      = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
        if (step_tokens.size() == 2) begin
            double_bytes++;
        end
        foreach (step_tokens[i]) begin
            expected_tokens.push_back(step_tokens[i]);
        end

        // End of file restarts the offsets; otherwise advance, holding at the last offset.
        if (eof) begin
            scan_mode   = SCAN_IDLE;
            next_offset = '0;
            word_start  = '0;
            past_end    = 1'b0;
        end else if (next_offset == offset_t'(MAX_OFFSET)) begin
            past_end = 1'b1;
        end else begin
            next_offset = next_offset + offset_t'(1);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Idle length for either side: mostly none, some short, a few long,
    // with occasional calm stretches where nothing idles at all.
    function automatic int idle_span(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic put(input logic [7:0] b);
        source_words.push_back('{code: b, pause: 8'(idle_span(send_calm)), drain: drain_next});
        drain_next = 1'b0;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put(s[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next word, hold it until accepted, then idle
    // for the gap drawn with it. Predict on acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                lex_byte(s_byte_in);
                bytes_taken++;
            end
            if (s_valid && !s_ready) begin
                // hold the word and its byte
            end else if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if ((source_words.size() == 0) ||
                         (source_words[0].drain && (expected_tokens.size() != 0))) begin
                // nothing left, or drain every outstanding token first
                s_valid <= 1'b0;
            end else begin
                next_word = source_words.pop_front();
                s_byte_in <= next_word.code;
                s_valid   <= 1'b1;
                gap_left  = int'(next_word.pause);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted token against the oldest prediction,
    // then stall the sink for a random span.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                tokens_checked++;
                if (m_token_kind == KIND_EOF) files_closed++;
                if (m_offset_overflow) flagged_tokens++;
                if (expected_tokens.size() == 0) begin
                    $error("token with no byte behind it: kind %0d start %0d length %0d",
                           m_token_kind, m_token_start, m_token_length);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_token_kind);
                        fail_count++;
                    end
                    if (m_token_start !== want.start) begin
                        $error("token_start: expected %0d, got %0d", want.start, m_token_start);
                        fail_count++;
                    end
                    if (m_token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, m_token_length);
                        fail_count++;
                    end
                    if (m_offset_overflow !== want.ovf) begin
                        $error("offset_overflow: expected %0d, got %0d",
                               want.ovf, m_offset_overflow);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_last_of_run);
                        fail_count++;
                    end
                end
                stall_left = idle_span(recv_calm);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d tokens still due",
                     cycle_count, expected_tokens.size());
            $display("c_token_lexer_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int         next_drain;
        int         pick;
        int         n;
        logic [7:0] c;

        // Directed: identifier closed by punctuation in the same byte, lone
        // slash before an identifier, underscore and digit first, a high byte
        // closing an identifier, a line comment ended by carriage return, a
        // block comment whose opening star does not close it, and a block
        // comment cut off by the zero byte.
        put_text("Ab_9(");
        put_text("/x _7");
        put_text("z");
        put(8'hFF);
        put_text("//");
        put(CH_CR);
        put(CH_TAB);
        put_text(".");
        put_text("/*/*/");
        put_text("/*");
        put(CH_NUL);

        // Random: mostly well-formed C-like fragments, some noise.
        next_drain = DRAIN_EVERY;
        while (source_words.size() < SOURCE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 24) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 6);
                put(word_chars[$urandom_range(0, 51)]);
                repeat (n) put(word_chars[$urandom_range(0, 62)]);
            end else if (pick < 44) begin
                put(punct_chars[$urandom_range(0, 10)]);
            end else if (pick < 62) begin
                repeat ($urandom_range(1, 3)) put(blanks[$urandom_range(0, 5)]);
            end else if (pick < 68) begin
                put(CH_SLASH);
                put(CH_SLASH);
                repeat ($urandom_range(0, 8)) put(8'($urandom_range(1, 255)));
                n = $urandom_range(0, 9);
                put((n == 0) ? CH_NUL : ((n < 5) ? CH_LF : CH_CR));
            end else if (pick < 75) begin
                put(CH_SLASH);
                put(CH_STAR);
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(0, 9);
                    put((n < 3) ? CH_STAR : ((n < 4) ? CH_SLASH : 8'($urandom_range(1, 255))));
                end
                if ($urandom_range(0, 9) == 0) begin
                    put(CH_NUL);
                end else begin
                    put(CH_STAR);
                    put(CH_SLASH);
                end
            end else if (pick < 80) begin
                // lone slash followed by anything that does not open a comment
                put(CH_SLASH);
                do c = 8'($urandom_range(0, 255)); while ((c == CH_SLASH) || (c == CH_STAR));
                put(c);
            end else if (pick < 88) begin
                n = $urandom_range(0, 2);
                if (n == 0) begin
                    put(8'($urandom_range(128, 255)));
                end else if (n == 1) begin
                    put(word_chars[$urandom_range(52, 61)]);
                end else begin
                    put(CH_UNDER);
                end
            end else if (pick < 97) begin
                put(8'($urandom_range(0, 255)));
            end else begin
                put(CH_NUL);
            end
            // Periodically let the sender drain the whole pipeline.
            if (source_words.size() >= next_drain) begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
        end

        // Close the last file so any pending token comes out.
        put(CH_NUL);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last byte to go in and every token to come back.
        while ((source_words.size() != 0) || s_valid) @(negedge aclk);
        while (expected_tokens.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("%0d source bytes lexed, %0d tokens checked over %0d files",
                 bytes_taken, tokens_checked, files_closed);
        $display("%0d bytes closed two tokens, %0d tokens carried the offset overflow flag",
                 double_bytes, flagged_tokens);
        if (fail_count == 0) begin
            $display("c_token_lexer_unit_test: PASS");
        end else begin
            $display("c_token_lexer_unit_test: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ctlex_pkg.sv
sv/ctlex_core.sv
sv/ctlex_fifo.sv
sv/c_token_lexer_unit.sv
tb/sv/c_token_lexer_unit_test.sv
